FILE: rtl/bfr_pkg.sv
// Shared types, codes and CRC byte-update functions for the bit-field reader.
package bfr_pkg;

  localparam logic [7:0]  CRC8_TAPS  = 8'h07;
  localparam logic [15:0] CRC16_TAPS = 16'h8005;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_READ      = 2'd1,
    OP_ALIGN     = 2'd2,
    OP_CRC_RESET = 2'd3
  } bfr_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NEED_MORE = 2'd1,
    ST_FULL      = 2'd2
  } bfr_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_FEED,
    S_EXTRACT,
    S_FINISH
  } bfr_state_e;

  typedef struct packed {
    bfr_op_e     operation;
    logic [7:0]  byte_in;
    logic [5:0]  field_bits;
    logic        big_endian;
    logic        sign_extend;
  } bfr_in_t;

  typedef struct packed {
    logic [31:0] field_value;
    bfr_status_e status;
    logic [7:0]  crc8_value;
    logic [15:0] crc16_value;
    logic        crc8_zero;
    logic        crc16_zero;
    logic [5:0]  bits_held;
  } bfr_out_t;

  // MSB-first CRC-8 over one byte, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_TAPS) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // MSB-first CRC-16 over one byte, no reflection
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_TAPS) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/bit_field_reader_crc.sv
// Bit-field reader over a byte FIFO with running CRC-8 and CRC-16.
// Push, align, CRC reset, zero-bit or short read: EXEC, FINISH. Read from held bits: EXEC,
// EXTRACT, FINISH. Read drawing k bytes (1..4 at 32 bits): EXEC, FETCH (registered RAM read),
// then FEED takes one FIFO byte per cycle through the CRC/shift unit, then EXTRACT, FINISH.
// Next input transfer in the cycle after the result registers, even while that result waits.
// Reset clears bit buffer, FIFO pointers and both CRCs; FIFO data is not cleared.
module bit_field_reader_crc #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bfr_pkg::bfr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bfr_pkg::bfr_out_t out_data_o
);

  localparam int STORE_W = MAX_FIELD_BITS + 8;
  localparam int CNT_W   = $clog2(STORE_W);
  localparam int N_W     = $clog2(MAX_FIELD_BITS + 1);
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = $clog2(2 * QUEUE_DEPTH);
  localparam int CMP_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  bfr_pkg::bfr_state_e  state_q, state_d;
  bfr_pkg::bfr_op_e     op_q, op_d;
  logic [7:0]           byte_q, byte_d;
  logic [N_W-1:0]       n_q, n_d;
  logic                 big_q, big_d;
  logic                 sext_q, sext_d;
  logic [STORE_W-1:0]   store_q, store_d;
  logic [CNT_W-1:0]     bc_q, bc_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [7:0]           crc8_q, crc8_d;
  logic [15:0]          crc16_q, crc16_d;
  logic [31:0]          res_value_q, res_value_d;
  bfr_pkg::bfr_status_e res_status_q, res_status_d;
  bfr_pkg::bfr_out_t    out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 in_xfer;
  logic [SUM_W-1:0]     tail_sum;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     head_inc;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [7:0]           ram_rdata;
  logic [CNT_W-1:0]     need_diff;
  logic [CNT_W-1:0]     needed;
  logic [CNT_W-1:0]     bc_rem;
  logic [CNT_W-1:0]     bc_feed;
  logic [STORE_W-1:0]   mask_n;
  logic [STORE_W-1:0]   val_wide;
  logic [31:0]          value32;
  logic [31:0]          mask32;
  logic [4:0]           sign_idx;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != bfr_pkg::S_IDLE);

  // Write slot: head + fill, wrapped once
  assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
  assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
  assign head_inc = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

  // Prefetch the next byte while the current one is consumed
  assign ram_raddr = (state_q == bfr_pkg::S_FEED) ? head_inc : head_q;
  assign ram_we    = (state_q == bfr_pkg::S_EXEC) && (op_q == bfr_pkg::OP_PUSH) &&
                     (fill_q < FILL_W'(QUEUE_DEPTH));

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail),
    .wdata_i (byte_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign need_diff = CNT_W'(n_q) - bc_q;
  assign needed    = (need_diff + CNT_W'(7)) >> 3;
  assign bc_rem    = bc_q - CNT_W'(n_q);
  assign bc_feed   = bc_q + CNT_W'(8);
  assign mask_n    = (STORE_W'(1) << n_q) - STORE_W'(1);
  assign val_wide  = big_q ? ((store_q >> bc_rem) & mask_n) : (store_q & mask_n);
  assign mask32    = (32'(1) << n_q) - 32'(1);
  assign sign_idx  = 5'(n_q - N_W'(1));

  always_comb begin
    value32 = 32'(val_wide);
    if (sext_q && value32[sign_idx]) begin
      value32 = value32 | ~mask32;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    byte_d       = byte_q;
    n_d          = n_q;
    big_d        = big_q;
    sext_d       = sext_q;
    store_d      = store_q;
    bc_d         = bc_q;
    head_d       = head_q;
    fill_d       = fill_q;
    crc8_d       = crc8_q;
    crc16_d      = crc16_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bfr_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_d   = in_data_i.operation;
          byte_d = in_data_i.byte_in;
          big_d  = in_data_i.big_endian;
          sext_d = in_data_i.sign_extend;
          n_d    = (in_data_i.field_bits > 6'(MAX_FIELD_BITS)) ?
                   N_W'(MAX_FIELD_BITS) : N_W'(in_data_i.field_bits);
          state_d = bfr_pkg::S_EXEC;
        end
      end
      bfr_pkg::S_EXEC: begin
        res_value_d  = '0;
        res_status_d = bfr_pkg::ST_OK;
        state_d      = bfr_pkg::S_FINISH;
        case (op_q)
          bfr_pkg::OP_PUSH: begin
            if (fill_q < FILL_W'(QUEUE_DEPTH)) begin
              fill_d = fill_q + FILL_W'(1);
            end else begin
              res_status_d = bfr_pkg::ST_FULL;
            end
          end
          bfr_pkg::OP_READ: begin
            if (n_q == '0) begin
              state_d = bfr_pkg::S_FINISH;
            end else if (CMP_W'(bc_q) >= CMP_W'(n_q)) begin
              state_d = bfr_pkg::S_EXTRACT;
            end else if (CMP_W'(fill_q) < CMP_W'(needed)) begin
              res_status_d = bfr_pkg::ST_NEED_MORE;
            end else begin
              state_d = bfr_pkg::S_FETCH;
            end
          end
          bfr_pkg::OP_ALIGN: begin
            store_d = '0;
            bc_d    = '0;
          end
          bfr_pkg::OP_CRC_RESET: begin
            crc8_d  = '0;
            crc16_d = '0;
          end
          default: begin
            state_d = bfr_pkg::S_FINISH;
          end
        endcase
      end
      bfr_pkg::S_FETCH: begin
        state_d = bfr_pkg::S_FEED;
      end
      bfr_pkg::S_FEED: begin
        // Consume one byte: CRC update, merge into the bit buffer, pop
        crc8_d  = bfr_pkg::crc8_byte(crc8_q, ram_rdata);
        crc16_d = bfr_pkg::crc16_byte(crc16_q, ram_rdata);
        if (big_q) begin
          store_d = (store_q << 8) | STORE_W'(ram_rdata);
        end else begin
          store_d = store_q | (STORE_W'(ram_rdata) << bc_q);
        end
        bc_d   = bc_feed;
        head_d = head_inc;
        fill_d = fill_q - FILL_W'(1);
        if (CMP_W'(bc_feed) >= CMP_W'(n_q)) begin
          state_d = bfr_pkg::S_EXTRACT;
        end
      end
      bfr_pkg::S_EXTRACT: begin
        res_value_d = value32;
        bc_d        = bc_rem;
        if (big_q) begin
          store_d = store_q & ((STORE_W'(1) << bc_rem) - STORE_W'(1));
        end else begin
          store_d = store_q >> n_q;
        end
        state_d = bfr_pkg::S_FINISH;
      end
      bfr_pkg::S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.field_value = res_value_q;
          out_d.status      = res_status_q;
          out_d.crc8_value  = crc8_q;
          out_d.crc16_value = crc16_q;
          out_d.crc8_zero   = (crc8_q == '0);
          out_d.crc16_zero  = (crc16_q == '0);
          out_d.bits_held   = 6'(bc_q);
          out_valid_d       = 1'b1;
          state_d           = bfr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bfr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfr_pkg::S_IDLE;
      store_q     <= '0;
      bc_q        <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      crc8_q      <= '0;
      crc16_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      store_q     <= store_d;
      bc_q        <= bc_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      crc8_q      <= crc8_d;
      crc16_q     <= crc16_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    byte_q       <= byte_d;
    n_q          <= n_d;
    big_q        <= big_d;
    sext_q       <= sext_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(QUEUE_DEPTH))
    else $error("byte FIFO fill beyond depth");

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(bc_q) < CMP_W'(STORE_W))
    else $error("bit buffer count beyond buffer width");

  a_feed_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfr_pkg::S_FEED) |-> (fill_q != '0))
    else $error("byte drawn from an empty FIFO");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (in_stall_o && !$past(out_valid_q && out_stall_i) || in_stall_o))
    else $error("input taken without entering the sequencer");

endmodule

FILE: rtl/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the bit-field reader with running CRC-8 and CRC-16.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FIFO_DEPTH  = 8;
  localparam int          MAX_BITS    = 32;
  localparam logic [8:0]  CRC8_GEN    = 9'h107;
  localparam logic [16:0] CRC16_GEN   = 17'h18005;
  localparam int          NUM_RANDOM  = 1950;
  localparam int          NUM_PHASES  = 4;
  localparam int          LONG_HOLD   = 300;
  localparam int          BURST_ITEMS = 40;
  localparam int          TAIL_CYCLES = 16;

  // results that can be read straight off the definition
  localparam bfr_pkg::bfr_out_t RES_CLEAR = '{field_value: '0, status: bfr_pkg::ST_OK,
                                              crc8_value: '0, crc16_value: '0,
                                              crc8_zero: 1'b1, crc16_zero: 1'b1,
                                              bits_held: '0};
  localparam bfr_pkg::bfr_out_t RES_NEED_MORE = '{field_value: '0,
                                                  status: bfr_pkg::ST_NEED_MORE,
                                                  crc8_value: '0, crc16_value: '0,
                                                  crc8_zero: 1'b1, crc16_zero: 1'b1,
                                                  bits_held: '0};
  localparam bfr_pkg::bfr_out_t RES_FULL = '{field_value: '0, status: bfr_pkg::ST_FULL,
                                             crc8_value: '0, crc16_value: '0,
                                             crc8_zero: 1'b1, crc16_zero: 1'b1,
                                             bits_held: '0};

  typedef struct packed {
    bfr_pkg::bfr_in_t  stim;
    logic              typed;
    bfr_pkg::bfr_out_t res;
  } dir_row_t;

  localparam int NUM_DIR = 25;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd8,  1'b1, 1'b0}, 1'b1, RES_NEED_MORE},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd0,  1'b0, 1'b1}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_ALIGN,     8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_CRC_RESET, 8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'hFF, 6'd63, 1'b1, 1'b1}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'h80, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'h01, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'hA5, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'h5A, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'hFF, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR},
    '{'{bfr_pkg::OP_PUSH,      8'h3C, 6'd0,  1'b0, 1'b0}, 1'b1, RES_FULL},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd32, 1'b1, 1'b1}, 1'b0, '0},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd63, 1'b0, 1'b1}, 1'b0, '0},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd1,  1'b1, 1'b1}, 1'b0, '0},
    '{'{bfr_pkg::OP_PUSH,      8'h80, 6'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd1,  1'b1, 1'b1}, 1'b0, '0},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd7,  1'b0, 1'b1}, 1'b0, '0},
    '{'{bfr_pkg::OP_PUSH,      8'h7F, 6'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{bfr_pkg::OP_PUSH,      8'hC3, 6'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd12, 1'b1, 1'b0}, 1'b0, '0},
    '{'{bfr_pkg::OP_READ,      8'h00, 6'd4,  1'b0, 1'b1}, 1'b0, '0},
    '{'{bfr_pkg::OP_ALIGN,     8'h00, 6'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{bfr_pkg::OP_CRC_RESET, 8'h00, 6'd0,  1'b0, 1'b0}, 1'b1, RES_CLEAR}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  bfr_pkg::bfr_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  bfr_pkg::bfr_out_t out_data_o;

  // reader state as the testbench tracks it
  logic [39:0]       rd_store;
  int unsigned       rd_count;
  logic [7:0]        byte_fifo [FIFO_DEPTH];
  int unsigned       fifo_head;
  int unsigned       fifo_fill;
  logic [7:0]        run_crc8;
  logic [15:0]       run_crc16;

  bfr_pkg::bfr_out_t pending_results [$];
  int unsigned       mismatch_count;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  bit                long_hold_req;

  bit_field_reader_crc dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Advance the tracked reader state by one item and return its result.
  function automatic bfr_pkg::bfr_out_t reader_step(bfr_pkg::bfr_in_t it);
    bfr_pkg::bfr_out_t r;
    int unsigned       n;
    int unsigned       needed;
    logic [63:0]       fmask;
    logic [7:0]        b;
    logic [8:0]        c8;
    logic [16:0]       c16;
    r = '0;
    r.status = bfr_pkg::ST_OK;
    case (it.operation)
      bfr_pkg::OP_PUSH: begin
        if (fifo_fill >= FIFO_DEPTH) begin
          r.status = bfr_pkg::ST_FULL;
        end else begin
          byte_fifo[(fifo_head + fifo_fill) % FIFO_DEPTH] = it.byte_in;
          fifo_fill++;
        end
      end
      bfr_pkg::OP_READ: begin
        n = (it.field_bits > MAX_BITS) ? MAX_BITS : it.field_bits;
        needed = (n > rd_count) ? (n - rd_count + 7) / 8 : 0;
        if (n != 0 && fifo_fill < needed) begin
          r.status = bfr_pkg::ST_NEED_MORE;
        end else if (n != 0) begin
          while (rd_count < n) begin
            b = byte_fifo[fifo_head];
            fifo_head = (fifo_head + 1) % FIFO_DEPTH;
            fifo_fill--;
            c8 = {1'b0, run_crc8 ^ b};
            c16 = {1'b0, run_crc16 ^ {b, 8'h00}};
            for (int i = 0; i < 8; i++) begin
              c8 = c8[7] ? ({c8[7:0], 1'b0} ^ CRC8_GEN) : {c8[7:0], 1'b0};
              c16 = c16[15] ? ({c16[15:0], 1'b0} ^ CRC16_GEN) : {c16[15:0], 1'b0};
            end
            run_crc8 = c8[7:0];
            run_crc16 = c16[15:0];
            if (it.big_endian) begin
              rd_store = {rd_store[31:0], b};
            end else begin
              rd_store = rd_store | (40'(b) << rd_count);
            end
            rd_count += 8;
          end
          fmask = (64'd1 << n) - 64'd1;
          rd_count -= n;
          if (it.big_endian) begin
            r.field_value = 32'((64'(rd_store) >> rd_count) & fmask);
            rd_store = rd_store & 40'((64'd1 << rd_count) - 64'd1);
          end else begin
            r.field_value = 32'(64'(rd_store) & fmask);
            rd_store = rd_store >> n;
          end
          if (it.sign_extend && n < 32 && r.field_value[n-1]) begin
            r.field_value = r.field_value | ~fmask[31:0];
          end
        end
      end
      bfr_pkg::OP_ALIGN: begin
        rd_store = '0;
        rd_count = 0;
      end
      default: begin
        run_crc8 = '0;
        run_crc16 = '0;
      end
    endcase
    r.crc8_value = run_crc8;
    r.crc16_value = run_crc16;
    r.crc8_zero = (run_crc8 == '0);
    r.crc16_zero = (run_crc16 == '0);
    r.bits_held = 6'(rd_count);
    return r;
  endfunction

  function automatic bfr_pkg::bfr_in_t random_item();
    bfr_pkg::bfr_in_t it;
    int unsigned      pick;
    it.byte_in = 8'($urandom);
    it.big_endian = 1'($urandom_range(1));
    it.sign_extend = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 85) begin
      it.field_bits = 6'($urandom_range(32, 1));
    end else if (pick < 92) begin
      it.field_bits = '0;
    end else begin
      it.field_bits = 6'($urandom_range(63, 33));
    end
    pick = $urandom_range(99);
    if (pick < 46) begin
      it.operation = bfr_pkg::OP_PUSH;
    end else if (pick < 92) begin
      it.operation = bfr_pkg::OP_READ;
    end else if (pick < 96) begin
      it.operation = bfr_pkg::OP_ALIGN;
    end else begin
      it.operation = bfr_pkg::OP_CRC_RESET;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(bfr_pkg::bfr_in_t it, logic typed, bfr_pkg::bfr_out_t typed_res);
    bfr_pkg::bfr_out_t want;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    want = reader_step(it);
    if (typed) begin
      want = typed_res;
    end
    pending_results.push_back(want);
  endtask

  task automatic idle_input(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver side: random stall, with a long hold when the stimulus asks for one
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bfr_pkg::bfr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", 32'(out_data_o.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.field_value !== want.field_value)
          report_mismatch("field_value", out_data_o.field_value, want.field_value);
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        if (out_data_o.crc8_value !== want.crc8_value)
          report_mismatch("crc8_value", 32'(out_data_o.crc8_value), 32'(want.crc8_value));
        if (out_data_o.crc16_value !== want.crc16_value)
          report_mismatch("crc16_value", 32'(out_data_o.crc16_value), 32'(want.crc16_value));
        if (out_data_o.crc8_zero !== want.crc8_zero)
          report_mismatch("crc8_zero", 32'(out_data_o.crc8_zero), 32'(want.crc8_zero));
        if (out_data_o.crc16_zero !== want.crc16_zero)
          report_mismatch("crc16_zero", 32'(out_data_o.crc16_zero), 32'(want.crc16_zero));
        if (out_data_o.bits_held !== want.bits_held)
          report_mismatch("bits_held", 32'(out_data_o.bits_held), 32'(want.bits_held));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    long_hold_req = 1'b0;
    mismatch_count = 0;
    rd_store = '0;
    rd_count = 0;
    fifo_head = 0;
    fifo_fill = 0;
    run_crc8 = '0;
    run_crc16 = '0;
    foreach (byte_fifo[i]) byte_fifo[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].res);
    end
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int k = 0; k < NUM_RANDOM / NUM_PHASES; k++) begin
        while ($urandom_range(99) < idle_pct) begin
          idle_input(1);
        end
        send_item(random_item(), 1'b0, '0);
      end
      if (ph == 1) begin
        // hold the output for a long stretch while items keep coming
        long_hold_req = 1'b1;
        for (int k = 0; k < BURST_ITEMS; k++) begin
          send_item(random_item(), 1'b0, '0);
        end
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bfr_pkg.sv
rtl/bfr_ram.sv
rtl/bit_field_reader_crc.sv
dv/tb.sv
